[sv/lrms_pkg.sv]
//------------------------------------------------------------------------------
// lrms_pkg
// types and constants shared by the mode supervisor modules
//------------------------------------------------------------------------------
package lrms_pkg;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_INIT   = 3'd1;
    localparam logic [2:0] CMD_SYSREQ = 3'd2;
    localparam logic [2:0] CMD_ROBREQ = 3'd3;
    localparam logic [2:0] CMD_LEG    = 3'd4;
    localparam logic [2:0] CMD_MOTION = 3'd5;
    localparam logic [2:0] CMD_ESTOP  = 3'd6;

    localparam logic [1:0] R_UNKNOWN = 2'd0;
    localparam logic [1:0] R_PACKED  = 2'd1;
    localparam logic [1:0] R_READY   = 2'd2;
    localparam logic [1:0] R_RUNNING = 2'd3;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_BUSY    = 3'd1;
    localparam logic [2:0] ERR_BADTR   = 3'd2;
    localparam logic [2:0] ERR_BADLEG  = 3'd3;
    localparam logic [2:0] ERR_NOTRUN  = 3'd4;
    localparam logic [2:0] ERR_LIMIT   = 3'd5;
    localparam logic [2:0] ERR_TIMEOUT = 3'd6;

    localparam logic [1:0] REG_SEQ_EN   = 2'd0;
    localparam logic [1:0] REG_MAN_LIM  = 2'd1;
    localparam logic [1:0] REG_PACK     = 2'd2;
    localparam logic [1:0] REG_RUN_TO   = 2'd3;

    localparam logic [6:0] PCT_STEP1 = 7'd33;
    localparam logic [6:0] PCT_STEP2 = 7'd66;
    localparam logic [6:0] PCT_FULL  = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic div_step;
        logic finish;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } ctrl_status_t;

endpackage

[sv/lrms_ctrl.sv]
//------------------------------------------------------------------------------
// lrms_ctrl
// sequencer for one beat: execute, optional progress divide, finish, output
//------------------------------------------------------------------------------
module lrms_ctrl
    import lrms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  logic         out_free,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd,
    output logic         busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.need_div || status.div_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/lrms_dp.sv]
//------------------------------------------------------------------------------
// lrms_dp
// supervisor state, command execution and restoring progress divider
//------------------------------------------------------------------------------
module lrms_dp
    import lrms_pkg::*;
#(
    parameter int LEG_COUNT = 6
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    ctl,
    output ctrl_status_t status,
    input  logic         in_fire,
    input  logic [2:0]   cmd_in,
    input  logic [1:0]   target_in,
    input  logic [2:0]   leg_in,
    input  logic [1:0]   mode_in,
    input  logic         motion_in,
    input  logic [1:0]   pose_in,
    input  logic         seq_en,
    input  logic [2:0]   man_lim,
    input  logic [15:0]  pack_ms,
    input  logic [15:0]  run_ms,
    output logic         r_ok,
    output logic [2:0]   r_err,
    output logic         r_sys,
    output logic [1:0]   r_robot,
    output logic [1:0]   r_walk,
    output logic         r_trans,
    output logic [6:0]   r_prog,
    output logic [1:0]   r_step,
    output logic [2:0]   r_man,
    output logic         r_errf
);

    logic [2:0]  c_cmd_reg;
    logic [1:0]  c_tgt_reg;
    logic [2:0]  c_leg_reg;
    logic [1:0]  c_mode_reg;
    logic        c_mot_reg;
    logic [1:0]  c_pose_reg;

    logic        init_reg, sys_now_reg, sys_want_reg;
    logic [1:0]  rob_now_reg, rob_want_reg, walk_reg;
    logic        tact_reg;
    logic [16:0] tel_reg;
    logic [15:0] sel_reg;
    logic        srun_reg;
    logic [1:0]  step_reg;
    logic [1:0]  legs_reg [LEG_COUNT];
    logic        mot_reg;
    logic [6:0]  prog_reg;
    logic        errs_reg;
    logic        ok_reg;
    logic [2:0]  err_reg;
    logic        pdone_reg;
    logic        need_div_reg;

    logic [22:0] num_reg;
    logic [15:0] rem_reg;
    logic [6:0]  quo_reg;
    logic [4:0]  dcnt_reg;

    logic        init_next, sys_now_next, sys_want_next;
    logic [1:0]  rob_now_next, rob_want_next, walk_next;
    logic        tact_next;
    logic [16:0] tel_next;
    logic [15:0] sel_next;
    logic        srun_next;
    logic [1:0]  step_next;
    logic [1:0]  legs_next [LEG_COUNT];
    logic        mot_next;
    logic [6:0]  prog_next;
    logic        errs_next;
    logic        ok_next;
    logic [2:0]  err_next;
    logic        pdone_next;
    logic        need_div_next;
    logic [22:0] num_next;

    logic [2:0]  man_sat;
    logic [17:0] lim;
    logic        move_ok;
    logic        was_c, will_c;
    logic [2:0]  leg_sel;
    logic [1:0]  leg_old;
    logic [16:0] rem_sh;
    logic [16:0] rem_sub;

    function automatic logic leg_in_range(input logic [2:0] l);
        leg_in_range = ({29'd0, l} < LEG_COUNT);
    endfunction

    function automatic logic [2:0] count_legs(input logic [1:0] lm [LEG_COUNT]);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < LEG_COUNT; i++)
        begin
            if (lm[i] == 2'd1 || lm[i] == 2'd2)
            begin
                n = n + 4'd1;
            end
        end
        count_legs = (n > 4'd7) ? 3'd7 : n[2:0];
    endfunction

    assign leg_sel = leg_in_range(c_leg_reg) ? c_leg_reg : 3'd0;
    assign leg_old = legs_reg[leg_sel[$clog2(LEG_COUNT > 1 ? LEG_COUNT : 2)-1:0]];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            c_cmd_reg  <= cmd_in;
            c_tgt_reg  <= target_in;
            c_leg_reg  <= leg_in;
            c_mode_reg <= mode_in;
            c_mot_reg  <= motion_in;
            c_pose_reg <= pose_in;
        end
    end

    // main execution, leaves timed progress division pending
    always_comb
    begin
        init_next     = init_reg;
        sys_now_next  = sys_now_reg;
        sys_want_next = sys_want_reg;
        rob_now_next  = rob_now_reg;
        rob_want_next = rob_want_reg;
        walk_next     = walk_reg;
        tact_next     = tact_reg;
        tel_next      = tel_reg;
        sel_next      = sel_reg;
        srun_next     = srun_reg;
        step_next     = step_reg;
        legs_next     = legs_reg;
        mot_next      = mot_reg;
        prog_next     = prog_reg;
        errs_next     = errs_reg;
        ok_next       = 1'b1;
        err_next      = ERR_NONE;
        pdone_next    = 1'b0;
        need_div_next = 1'b0;
        num_next      = '0;
        man_sat       = count_legs(legs_reg);
        lim           = '0;
        move_ok       = 1'b0;
        was_c         = 1'b0;
        will_c        = 1'b0;
        case (c_cmd_reg)
            CMD_TICK:
            begin
                if (init_reg)
                begin
                    if (sys_now_reg != sys_want_reg)
                    begin
                        if (!sys_want_reg)
                        begin
                            mot_next  = 1'b0;
                            tact_next = 1'b0;
                            srun_next = 1'b0;
                            sel_next  = '0;
                            if (rob_now_reg == R_RUNNING)
                            begin
                                walk_next = 2'd0;
                            end
                            errs_next    = 1'b0;
                            sys_now_next = 1'b0;
                        end
                        else
                        begin
                            sys_now_next = 1'b1;
                            errs_next    = 1'b0;
                        end
                    end
                    if (tact_next)
                    begin
                        if (tel_next != 17'h1FFFF)
                        begin
                            tel_next = tel_next + 17'd1;
                        end
                        lim = (rob_want_next == R_PACKED || rob_want_next == R_READY)
                            ? {1'b0, pack_ms, 1'b0} : {2'b00, run_ms};
                        if ({1'b0, tel_next} > lim)
                        begin
                            errs_next = 1'b1;
                            tact_next = 1'b0;
                            srun_next = 1'b0;
                            sel_next  = '0;
                            err_next  = ERR_TIMEOUT;
                        end
                    end
                    if (rob_now_next != R_RUNNING)
                    begin
                        walk_next = 2'd0;
                    end
                    else
                    begin
                        case (walk_next)
                            2'd0: if (mot_next) walk_next = 2'd1;
                            2'd1: walk_next = 2'd2;
                            2'd2: if (!mot_next) walk_next = 2'd3;
                            default: walk_next = 2'd0;
                        endcase
                    end
                    if (tact_next)
                    begin
                        if (rob_now_next == rob_want_next)
                        begin
                            tact_next = 1'b0;
                            srun_next = 1'b0;
                            sel_next  = '0;
                        end
                        else
                        begin
                            case (rob_now_next)
                                R_UNKNOWN:
                                begin
                                    rob_now_next = (c_pose_reg == 2'd2) ? R_READY : R_PACKED;
                                    tact_next    = 1'b0;
                                    srun_next    = 1'b0;
                                    sel_next     = '0;
                                    prog_next    = '0;
                                    pdone_next   = 1'b1;
                                end
                                R_PACKED:
                                begin
                                    need_div_next = (rob_want_next == R_READY)
                                        || (rob_want_next == R_RUNNING && !seq_en);
                                    if (!need_div_next)
                                    begin
                                        prog_next  = '0;
                                        pdone_next = 1'b1;
                                    end
                                end
                                R_READY:
                                begin
                                    if (rob_want_next == R_PACKED)
                                    begin
                                        need_div_next = 1'b1;
                                    end
                                    else if (rob_want_next == R_RUNNING)
                                    begin
                                        if (seq_en)
                                        begin
                                            pdone_next = 1'b1;
                                            if (!srun_next)
                                            begin
                                                srun_next = 1'b1;
                                                step_next = 2'd1;
                                                prog_next = PCT_STEP1;
                                            end
                                            else if (step_next == 2'd1)
                                            begin
                                                step_next = 2'd2;
                                                prog_next = PCT_STEP2;
                                            end
                                            else
                                            begin
                                                step_next = 2'd3;
                                                srun_next = 1'b0;
                                                prog_next = PCT_FULL;
                                            end
                                        end
                                        else
                                        begin
                                            rob_now_next = R_RUNNING;
                                            walk_next    = 2'd0;
                                            prog_next    = PCT_FULL;
                                            pdone_next   = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        prog_next  = '0;
                                        pdone_next = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    if (rob_want_next == R_READY)
                                    begin
                                        if (walk_next != 2'd0)
                                        begin
                                            mot_next = 1'b0;
                                        end
                                        else
                                        begin
                                            pdone_next = 1'b1;
                                            if (!srun_next)
                                            begin
                                                srun_next = 1'b1;
                                                step_next = 2'd1;
                                                prog_next = PCT_STEP1;
                                            end
                                            else if (step_next == 2'd1)
                                            begin
                                                step_next = 2'd2;
                                                prog_next = PCT_STEP2;
                                            end
                                            else
                                            begin
                                                step_next = 2'd3;
                                                srun_next = 1'b0;
                                                prog_next = PCT_FULL;
                                            end
                                        end
                                    end
                                    else
                                    begin
                                        prog_next  = '0;
                                        pdone_next = 1'b1;
                                    end
                                end
                            endcase
                            if (need_div_next)
                            begin
                                if (!srun_next)
                                begin
                                    srun_next = 1'b1;
                                    sel_next  = '0;
                                    step_next = 2'd1;
                                end
                                else if (sel_next != 16'hFFFF)
                                begin
                                    sel_next = sel_next + 16'd1;
                                end
                                if (sel_next >= pack_ms)
                                begin
                                    srun_next     = 1'b0;
                                    sel_next      = '0;
                                    prog_next     = PCT_FULL;
                                    need_div_next = 1'b0;
                                    pdone_next    = 1'b1;
                                end
                                else
                                begin
                                    num_next = {1'b0, sel_next, 6'd0}
                                        + {2'd0, sel_next, 5'd0}
                                        + {5'd0, sel_next, 2'd0};
                                end
                            end
                        end
                    end
                    for (int i = 0; i < LEG_COUNT; i++)
                    begin
                        if (legs_next[i] == 2'd2 && walk_next == 2'd0)
                        begin
                            legs_next[i] = 2'd1;
                        end
                        else if (legs_next[i] == 2'd3)
                        begin
                            legs_next[i] = 2'd0;
                        end
                    end
                end
            end
            CMD_INIT:
            begin
                rob_now_next  = (c_pose_reg == 2'd1) ? R_PACKED
                              : (c_pose_reg == 2'd2) ? R_READY : R_UNKNOWN;
                rob_want_next = rob_now_next;
                sys_now_next  = 1'b1;
                sys_want_next = 1'b1;
                init_next     = 1'b1;
                errs_next     = 1'b0;
            end
            CMD_SYSREQ:
            begin
                if (c_tgt_reg != {1'b0, sys_now_reg})
                begin
                    if (c_tgt_reg[1])
                    begin
                        ok_next  = 1'b0;
                        err_next = ERR_BADTR;
                    end
                    else if (tact_reg)
                    begin
                        ok_next  = 1'b0;
                        err_next = ERR_BUSY;
                    end
                    else
                    begin
                        sys_want_next = c_tgt_reg[0];
                    end
                end
            end
            CMD_ROBREQ:
            begin
                if (c_tgt_reg != rob_now_reg)
                begin
                    unique case (rob_now_reg)
                        R_UNKNOWN: move_ok = 1'b1;
                        R_PACKED:  move_ok = (c_tgt_reg == R_READY)
                                          || (c_tgt_reg == R_RUNNING && !seq_en);
                        R_READY:   move_ok = (c_tgt_reg == R_PACKED)
                                          || (c_tgt_reg == R_RUNNING);
                        default:   move_ok = (c_tgt_reg == R_READY)
                                          || (c_tgt_reg == R_PACKED && !seq_en);
                    endcase
                    if (!move_ok)
                    begin
                        ok_next  = 1'b0;
                        err_next = ERR_BADTR;
                    end
                    else if (tact_reg)
                    begin
                        ok_next  = 1'b0;
                        err_next = ERR_BUSY;
                    end
                    else
                    begin
                        rob_want_next = c_tgt_reg;
                        srun_next     = 1'b0;
                        sel_next      = '0;
                        tact_next     = 1'b1;
                        tel_next      = '0;
                    end
                end
            end
            CMD_LEG:
            begin
                if (!leg_in_range(c_leg_reg))
                begin
                    ok_next  = 1'b0;
                    err_next = ERR_BADLEG;
                end
                else if (rob_now_reg != R_RUNNING)
                begin
                    ok_next  = 1'b0;
                    err_next = ERR_NOTRUN;
                end
                else
                begin
                    was_c = (leg_old == 2'd1) || (leg_old == 2'd2);
                    will_c = (c_mode_reg == 2'd1) || (c_mode_reg == 2'd2);
                    if (will_c && !was_c && (man_sat >= man_lim))
                    begin
                        ok_next  = 1'b0;
                        err_next = ERR_LIMIT;
                    end
                    else
                    begin
                        for (int i = 0; i < LEG_COUNT; i++)
                        begin
                            if (3'(i) == c_leg_reg)
                            begin
                                legs_next[i] = c_mode_reg;
                            end
                        end
                    end
                end
            end
            CMD_MOTION:
            begin
                mot_next = c_mot_reg;
            end
            CMD_ESTOP:
            begin
                mot_next  = 1'b0;
                tact_next = 1'b0;
                srun_next = 1'b0;
                sel_next  = '0;
                if (rob_now_reg == R_RUNNING)
                begin
                    walk_next = 2'd0;
                end
                errs_next = 1'b0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        if (!ok_next && err_next != ERR_NONE)
        begin
            errs_next = 1'b1;
        end
    end

    assign status.need_div = need_div_reg;
    assign status.div_done = (dcnt_reg == 5'd23);

    assign rem_sh  = {rem_reg, num_reg[22]};
    assign rem_sub = rem_sh - {1'b0, pack_ms};

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            num_reg  <= num_next;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (ctl.div_step)
        begin
            num_reg <= {num_reg[21:0], 1'b0};
            if (rem_sh >= {1'b0, pack_ms})
            begin
                rem_reg <= rem_sub[15:0];
                quo_reg <= {quo_reg[5:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[15:0];
                quo_reg <= {quo_reg[5:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (ctl.exec)
        begin
            dcnt_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            dcnt_reg <= dcnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg     <= 1'b0;
            sys_now_reg  <= 1'b0;
            sys_want_reg <= 1'b0;
            rob_now_reg  <= R_UNKNOWN;
            rob_want_reg <= R_UNKNOWN;
            walk_reg     <= 2'd0;
            tact_reg     <= 1'b0;
            tel_reg      <= '0;
            sel_reg      <= '0;
            srun_reg     <= 1'b0;
            step_reg     <= 2'd0;
            for (int i = 0; i < LEG_COUNT; i++)
            begin
                legs_reg[i] <= 2'd0;
            end
            mot_reg      <= 1'b0;
            prog_reg     <= '0;
            errs_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            err_reg      <= ERR_NONE;
            pdone_reg    <= 1'b0;
            need_div_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            init_reg     <= init_next;
            sys_now_reg  <= sys_now_next;
            sys_want_reg <= sys_want_next;
            rob_now_reg  <= rob_now_next;
            rob_want_reg <= rob_want_next;
            walk_reg     <= walk_next;
            tact_reg     <= tact_next;
            tel_reg      <= tel_next;
            sel_reg      <= sel_next;
            srun_reg     <= srun_next;
            step_reg     <= step_next;
            legs_reg     <= legs_next;
            mot_reg      <= mot_next;
            prog_reg     <= prog_next;
            errs_reg     <= errs_next;
            ok_reg       <= ok_next;
            err_reg      <= err_next;
            pdone_reg    <= pdone_next;
            need_div_reg <= need_div_next;
        end
        else if (ctl.finish)
        begin
            if (need_div_reg)
            begin
                prog_reg <= quo_reg;
            end
            else if (pdone_reg && prog_reg == PCT_FULL && tact_reg)
            begin
                rob_now_reg <= rob_want_reg;
                tact_reg    <= 1'b0;
                srun_reg    <= 1'b0;
                sel_reg     <= '0;
            end
        end
    end

    assign r_ok    = ok_reg;
    assign r_err   = err_reg;
    assign r_sys   = sys_now_reg;
    assign r_robot = rob_now_reg;
    assign r_walk  = walk_reg;
    assign r_trans = tact_reg;
    assign r_prog  = prog_reg;
    assign r_step  = step_reg;
    assign r_man   = count_legs(legs_reg);
    assign r_errf  = errs_reg;

endmodule

[sv/legged_robot_mode_supervisor_unit.sv]
// each input beat runs through the exec, div, finish and out states; a pack or unpack tick
// also runs the 23-step restoring divider for progress percent
// input: one beat at a time, next input taken the cycle after the result register
// loads, and a result waits in the out state while the sink still holds the last one
// reset: rst_n asynchronous, clears sequencer, supervisor state and out_valid, and loads register reset values
//------------------------------------------------------------------------------
// legged_robot_mode_supervisor_unit
// robot mode supervisor top level with apb-style configuration port
//------------------------------------------------------------------------------
module legged_robot_mode_supervisor_unit
    import lrms_pkg::*;
#(
    parameter int LEG_COUNT = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [1:0]  target_state,
    input  logic [2:0]  leg_select,
    input  logic [1:0]  leg_mode,
    input  logic        motion_request,
    input  logic [1:0]  detected_pose,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [2:0]  error_code,
    output logic        system_state_out,
    output logic [1:0]  robot_state_out,
    output logic [1:0]  walk_state_out,
    output logic        in_transition,
    output logic [6:0]  progress_percent,
    output logic [1:0]  sequence_step,
    output logic [2:0]  manual_legs,
    output logic        error_flag
);

    logic        seq_en_reg;
    logic [2:0]  man_lim_reg;
    logic [15:0] pack_reg;
    logic [15:0] run_reg;
    logic        out_valid_reg;
    logic        busy;
    logic        in_fire;
    logic        out_free;
    ctrl_cmd_t    ctl;
    ctrl_status_t status;

    logic        r_ok, r_sys, r_trans, r_errf;
    logic [2:0]  r_err, r_man;
    logic [1:0]  r_robot, r_walk, r_step;
    logic [6:0]  r_prog;

    assign pready   = 1'b1;
    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_en_reg  <= 1'b0;
            man_lim_reg <= 3'd2;
            pack_reg    <= 16'd2000;
            run_reg     <= 16'd5000;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_SEQ_EN:  seq_en_reg  <= pwdata[0];
                REG_MAN_LIM: man_lim_reg <= pwdata[2:0];
                REG_PACK:    pack_reg    <= pwdata[15:0];
                default:     run_reg     <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SEQ_EN:  prdata = {31'd0, seq_en_reg};
            REG_MAN_LIM: prdata = {29'd0, man_lim_reg};
            REG_PACK:    prdata = {16'd0, pack_reg};
            default:     prdata = {16'd0, run_reg};
        endcase
    end

    lrms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .status   (status),
        .cmd      (ctl),
        .busy     (busy)
    );

    lrms_dp #(
        .LEG_COUNT (LEG_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .in_fire   (in_fire),
        .cmd_in    (cmd),
        .target_in (target_state),
        .leg_in    (leg_select),
        .mode_in   (leg_mode),
        .motion_in (motion_request),
        .pose_in   (detected_pose),
        .seq_en    (seq_en_reg),
        .man_lim   (man_lim_reg),
        .pack_ms   (pack_reg),
        .run_ms    (run_reg),
        .r_ok      (r_ok),
        .r_err     (r_err),
        .r_sys     (r_sys),
        .r_robot   (r_robot),
        .r_walk    (r_walk),
        .r_trans   (r_trans),
        .r_prog    (r_prog),
        .r_step    (r_step),
        .r_man     (r_man),
        .r_errf    (r_errf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            accepted         <= r_ok;
            error_code       <= r_err;
            system_state_out <= r_sys;
            robot_state_out  <= r_robot;
            walk_state_out   <= r_walk;
            in_transition    <= r_trans;
            progress_percent <= r_prog;
            sequence_step    <= r_step;
            manual_legs      <= r_man;
            error_flag       <= r_errf;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sim/tb_legged_robot_mode_supervisor_unit.sv]
//------------------------------------------------------------------------------
// tb_legged_robot_mode_supervisor_unit
// self-checking bench: a cycle-free model of the mode supervisor predicts each
// result beat from the accepted command beats, under random source gaps, sink
// stalls, one long sink hold-off and several register settings
//------------------------------------------------------------------------------
module tb_legged_robot_mode_supervisor_unit;
    import lrms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEG_TOTAL = 6;

    typedef struct {
        logic [2:0] cmd;
        logic [1:0] target;
        logic [2:0] leg;
        logic [1:0] mode;
        logic       motion;
        logic [1:0] pose;
    } command_t;

    typedef struct {
        logic       ok;
        logic [2:0] err;
        logic       sys;
        logic [1:0] robot;
        logic [1:0] walk;
        logic       in_tr;
        logic [6:0] pct;
        logic [1:0] step;
        logic [2:0] nman;
        logic       eflag;
    } status_t;

    class supervisor_scoreboard;
        bit          seq_en;
        bit [2:0]    man_lim;
        bit [15:0]   pack_ms;
        bit [15:0]   run_to_ms;

        bit          initialized;
        bit          sys_now;
        bit          sys_want;
        bit [1:0]    robot_now;
        bit [1:0]    robot_want;
        bit [1:0]    walk_now;
        bit          tr_active;
        int unsigned tr_elapsed;
        int unsigned seq_elapsed;
        bit          seq_running;
        bit [1:0]    step_cnt;
        bit [1:0]    legs [8];
        bit [2:0]    nman;
        bit          motion_flag;
        bit [6:0]    pct;
        bit          eflag;

        status_t     pending [$];
        int          failures;
        int          checked;

        function new();
            seq_en = 0;
            man_lim = 2;
            pack_ms = 2000;
            run_to_ms = 5000;
            failures = 0;
            checked = 0;
            for (int i = 0; i < 8; i++)
            begin
                legs[i] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_SEQ_EN:  seq_en = v[0];
                REG_MAN_LIM: man_lim = v[2:0];
                REG_PACK:    pack_ms = v[15:0];
                REG_RUN_TO:  run_to_ms = v[15:0];
                default:     ;
            endcase
        endfunction

        function void stop_sequence();
            tr_active = 0;
            seq_running = 0;
            seq_elapsed = 0;
        endfunction

        function void recount();
            int n;
            n = 0;
            for (int i = 0; i < LEG_TOTAL; i++)
            begin
                if (legs[i] == 2'd1 || legs[i] == 2'd2)
                    n++;
            end
            nman = (n > 7) ? 3'd7 : n[2:0];
        endfunction

        function void estop();
            motion_flag = 0;
            stop_sequence();
            if (robot_now == R_RUNNING)
                walk_now = 0;
            eflag = 0;
        endfunction

        function int unsigned timed_pct();
            if (!seq_running)
            begin
                seq_running = 1;
                seq_elapsed = 0;
                step_cnt = 1;
            end
            else if (seq_elapsed < 32'hFFFF)
                seq_elapsed++;
            if (seq_elapsed >= pack_ms)
            begin
                seq_running = 0;
                seq_elapsed = 0;
                return 100;
            end
            return (seq_elapsed * 100) / pack_ms;
        endfunction

        function int unsigned stepped_pct();
            if (!seq_running)
            begin
                seq_running = 1;
                step_cnt = 1;
                return PCT_STEP1;
            end
            if (step_cnt == 2'd1)
            begin
                step_cnt = 2;
                return PCT_STEP2;
            end
            step_cnt = 3;
            seq_running = 0;
            return PCT_FULL;
        endfunction

        function void advance(logic [1:0] pose);
            int unsigned p;
            p = 0;
            if (robot_now == robot_want)
            begin
                stop_sequence();
                return;
            end
            case (robot_now)
                R_UNKNOWN:
                begin
                    robot_now = (pose == 2'd2) ? R_READY : R_PACKED;
                    stop_sequence();
                end
                R_PACKED:
                begin
                    if (robot_want == R_READY || (robot_want == R_RUNNING && !seq_en))
                        p = timed_pct();
                end
                R_READY:
                begin
                    if (robot_want == R_PACKED)
                        p = timed_pct();
                    else if (robot_want == R_RUNNING)
                    begin
                        if (seq_en)
                            p = stepped_pct();
                        else
                        begin
                            robot_now = R_RUNNING;
                            walk_now = 0;
                            p = 100;
                        end
                    end
                end
                default:
                begin
                    if (robot_want == R_READY)
                    begin
                        if (walk_now != 0)
                        begin
                            motion_flag = 0;
                            return;
                        end
                        p = stepped_pct();
                    end
                end
            endcase
            pct = p[6:0];
            if (p == 100)
            begin
                robot_now = robot_want;
                stop_sequence();
            end
        endfunction

        function logic [2:0] tick(logic [1:0] pose);
            logic [2:0]  err;
            int unsigned lim;
            err = ERR_NONE;
            if (!initialized)
                return ERR_NONE;
            if (sys_now != sys_want)
            begin
                if (!sys_want)
                begin
                    estop();
                    sys_now = 0;
                end
                else
                begin
                    sys_now = 1;
                    eflag = 0;
                end
            end
            if (tr_active)
            begin
                if (tr_elapsed < 32'h1FFFF)
                    tr_elapsed++;
                lim = (robot_want == R_PACKED || robot_want == R_READY) ? 2 * pack_ms
                                                                       : run_to_ms;
                if (tr_elapsed > lim)
                begin
                    eflag = 1;
                    stop_sequence();
                    err = ERR_TIMEOUT;
                end
            end
            if (robot_now != R_RUNNING)
                walk_now = 0;
            else
                case (walk_now)
                    2'd0: if (motion_flag) walk_now = 1;
                    2'd1: walk_now = 2;
                    2'd2: if (!motion_flag) walk_now = 3;
                    default: walk_now = 0;
                endcase
            if (tr_active)
                advance(pose);
            for (int i = 0; i < LEG_TOTAL; i++)
            begin
                if (legs[i] == 2'd2 && walk_now == 0)
                    legs[i] = 1;
                else if (legs[i] == 2'd3)
                    legs[i] = 0;
            end
            recount();
            return err;
        endfunction

        function bit move_ok(logic [1:0] to);
            case (robot_now)
                R_UNKNOWN: return 1;
                R_PACKED:  return to == R_READY || (to == R_RUNNING && !seq_en);
                R_READY:   return to == R_PACKED || to == R_RUNNING;
                default:   return to == R_READY || (to == R_PACKED && !seq_en);
            endcase
        endfunction

        function void note(command_t c);
            status_t r;
            bit      ok;
            bit      was_cnt;
            bit      will_cnt;
            logic [2:0] err;
            ok = 1;
            err = ERR_NONE;
            case (c.cmd)
                CMD_TICK: err = tick(c.pose);
                CMD_INIT:
                begin
                    robot_now = (c.pose == 2'd1) ? R_PACKED :
                                (c.pose == 2'd2) ? R_READY : R_UNKNOWN;
                    robot_want = robot_now;
                    sys_now = 1;
                    sys_want = 1;
                    initialized = 1;
                    eflag = 0;
                end
                CMD_SYSREQ:
                begin
                    if (c.target != {1'b0, sys_now})
                    begin
                        if (c.target > 2'd1)
                        begin
                            ok = 0;
                            err = ERR_BADTR;
                        end
                        else if (tr_active)
                        begin
                            ok = 0;
                            err = ERR_BUSY;
                        end
                        else
                            sys_want = c.target[0];
                    end
                end
                CMD_ROBREQ:
                begin
                    if (c.target != robot_now)
                    begin
                        if (!move_ok(c.target))
                        begin
                            ok = 0;
                            err = ERR_BADTR;
                        end
                        else if (tr_active)
                        begin
                            ok = 0;
                            err = ERR_BUSY;
                        end
                        else
                        begin
                            robot_want = c.target;
                            stop_sequence();
                            tr_active = 1;
                            tr_elapsed = 0;
                        end
                    end
                end
                CMD_LEG:
                begin
                    if (c.leg >= LEG_TOTAL)
                    begin
                        ok = 0;
                        err = ERR_BADLEG;
                    end
                    else if (robot_now != R_RUNNING)
                    begin
                        ok = 0;
                        err = ERR_NOTRUN;
                    end
                    else
                    begin
                        was_cnt = legs[c.leg] == 2'd1 || legs[c.leg] == 2'd2;
                        will_cnt = c.mode == 2'd1 || c.mode == 2'd2;
                        if (will_cnt && !was_cnt && nman >= man_lim)
                        begin
                            ok = 0;
                            err = ERR_LIMIT;
                        end
                        else
                        begin
                            legs[c.leg] = c.mode;
                            recount();
                        end
                    end
                end
                CMD_MOTION: motion_flag = c.motion;
                CMD_ESTOP:  estop();
                default:    ok = 0;
            endcase
            if (!ok && err != ERR_NONE)
                eflag = 1;
            r.ok = ok;
            r.err = err;
            r.sys = sys_now;
            r.robot = robot_now;
            r.walk = walk_now;
            r.in_tr = tr_active;
            r.pct = pct;
            r.step = step_cnt;
            r.nman = nman;
            r.eflag = eflag;
            pending.push_back(r);
        endfunction

        function void cmp(string name, int e, int a);
            if (e != a)
            begin
                $error("%s: expected %0d, got %0d", name, e, a);
                failures++;
            end
        endfunction

        function void check(status_t a);
            status_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing pending");
                failures++;
                return;
            end
            e = pending.pop_front();
            checked++;
            cmp("accepted", e.ok, a.ok);
            cmp("error_code", e.err, a.err);
            cmp("system_state_out", e.sys, a.sys);
            cmp("robot_state_out", e.robot, a.robot);
            cmp("walk_state_out", e.walk, a.walk);
            cmp("in_transition", e.in_tr, a.in_tr);
            cmp("progress_percent", e.pct, a.pct);
            cmp("sequence_step", e.step, a.step);
            cmp("manual_legs", e.nman, a.nman);
            cmp("error_flag", e.eflag, a.eflag);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [1:0]  target_state;
    logic [2:0]  leg_select;
    logic [1:0]  leg_mode;
    logic        motion_request;
    logic [1:0]  detected_pose;
    logic        out_valid;
    logic        out_ready;
    logic        accepted;
    logic [2:0]  error_code;
    logic        system_state_out;
    logic [1:0]  robot_state_out;
    logic [1:0]  walk_state_out;
    logic        in_transition;
    logic [6:0]  progress_percent;
    logic [1:0]  sequence_step;
    logic [2:0]  manual_legs;
    logic        error_flag;

    supervisor_scoreboard sb = new();
    bit hold_req = 0;
    int burst_left = 0;
    int sent = 0;

    legged_robot_mode_supervisor_unit #(.LEG_COUNT(LEG_TOTAL)) u_top (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // sink stall pattern, with one long hold-off on request
    initial
    begin
        int cyc;
        int sel;
        out_ready = 1'b0;
        cyc = 0;
        sel = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_req = 0;
            end
            cyc++;
            if (cyc % 64 == 0)
                sel = $urandom_range(0, 2);
            case (sel)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= (cyc % 3 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        status_t a;
        if (rst_n && out_valid && out_ready)
        begin
            a.ok = accepted;
            a.err = error_code;
            a.sys = system_state_out;
            a.robot = robot_state_out;
            a.walk = walk_state_out;
            a.in_tr = in_transition;
            a.pct = progress_percent;
            a.step = sequence_step;
            a.nman = manual_legs;
            a.eflag = error_flag;
            sb.check(a);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic configure(bit en, int lim, int pk, int rt);
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        write_reg(REG_SEQ_EN, {31'd0, en});
        write_reg(REG_MAN_LIM, lim);
        write_reg(REG_PACK, pk);
        write_reg(REG_RUN_TO, rt);
    endtask

    task automatic send(command_t c);
        in_valid <= 1'b1;
        cmd <= c.cmd;
        target_state <= c.target;
        leg_select <= c.leg;
        leg_mode <= c.mode;
        motion_request <= c.motion;
        detected_pose <= c.pose;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note(c);
        sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    endtask

    task automatic send_cmd(logic [2:0] c, int tgt = 0, int lg = 0, int md = 0,
                            int mo = 0, int ps = 0);
        command_t it;
        it.cmd = c;
        it.target = 2'(tgt);
        it.leg = 3'(lg);
        it.mode = 2'(md);
        it.motion = 1'(mo);
        it.pose = 2'(ps);
        send(it);
    endtask

    task automatic send_random();
        command_t it;
        int w;
        it.cmd = CMD_TICK;
        it.target = 2'($urandom_range(0, 3));
        it.leg = 3'($urandom_range(0, 7));
        it.mode = 2'($urandom_range(0, 3));
        it.motion = 1'($urandom_range(0, 1));
        it.pose = 2'($urandom_range(0, 2));
        w = $urandom_range(0, 99);
        if (!sb.initialized || w < 2)
            it.cmd = CMD_INIT;
        else if (w < 50)
            it.cmd = CMD_TICK;
        else if (w < 62)
        begin
            it.cmd = CMD_ROBREQ;
            if ($urandom_range(0, 3) != 0)
                case (sb.robot_now)
                    R_PACKED:  it.target = $urandom_range(0, 1) ? R_READY : R_RUNNING;
                    R_READY:   it.target = $urandom_range(0, 2) ? R_RUNNING : R_PACKED;
                    R_RUNNING: it.target = $urandom_range(0, 2) ? R_READY : R_PACKED;
                    default:   it.target = 2'($urandom_range(1, 3));
                endcase
        end
        else if (w < 78)
        begin
            it.cmd = CMD_LEG;
            if ($urandom_range(0, 5) != 0)
                it.leg = 3'($urandom_range(0, LEG_TOTAL - 1));
        end
        else if (w < 88)
            it.cmd = CMD_MOTION;
        else if (w < 93)
        begin
            it.cmd = CMD_SYSREQ;
            if ($urandom_range(0, 3) != 0)
                it.target = 2'($urandom_range(0, 1));
        end
        else
            it.cmd = CMD_ESTOP;
        send(it);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        cmd = CMD_TICK;
        target_state = '0;
        leg_select = '0;
        leg_mode = '0;
        motion_request = 1'b0;
        detected_pose = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: corner commands under a short pack time
        configure(0, 2, 3, 10);
        send_cmd(CMD_TICK);
        send_cmd(CMD_LEG, 0, 0, 1);
        send_cmd(CMD_INIT, 0, 0, 0, 0, 0);
        send_cmd(CMD_ROBREQ, R_PACKED);
        send_cmd(CMD_TICK, 0, 0, 0, 0, 2);
        send_cmd(CMD_SYSREQ, 3);
        send_cmd(CMD_SYSREQ, 0);
        send_cmd(CMD_TICK);
        send_cmd(CMD_SYSREQ, 1);
        send_cmd(CMD_TICK);
        send_cmd(CMD_LEG, 0, 7, 1);
        send_cmd(CMD_LEG, 0, 2, 1);
        send_cmd(CMD_ROBREQ, R_RUNNING);
        send_cmd(CMD_ROBREQ, R_PACKED);
        send_cmd(CMD_TICK);
        send_cmd(CMD_LEG, 0, 0, 1);
        send_cmd(CMD_LEG, 0, 5, 2);
        send_cmd(CMD_LEG, 0, 3, 1);
        send_cmd(CMD_MOTION, 0, 0, 0, 1);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_LEG, 0, 0, 3);
        send_cmd(CMD_ESTOP);
        send_cmd(CMD_ROBREQ, R_PACKED);
        repeat (9) send_cmd(CMD_TICK);

        configure(1, 0, 1, 1);
        send_cmd(CMD_INIT, 0, 0, 0, 0, 2);
        send_cmd(CMD_ROBREQ, R_RUNNING);
        repeat (4) send_cmd(CMD_TICK);
        repeat (120) send_random();

        configure(1, 6, 4, 12);
        hold_req = 1;
        repeat (130) send_random();

        configure(0, 6, 65535, 65535);
        repeat (50) send_random();

        configure(1, 3, 8, 25);
        repeat (130) send_random();

        configure(0, 1, 2, 6);
        repeat (130) send_random();

        configure(1, 2, 5, 65535);
        repeat (100) send_random();

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        $display("sent %0d command beats, checked %0d result beats over seven register settings",
                 sent, sb.checked);
        $display("mismatches: %0d", sb.failures);
        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
